### sv/bmg_pkg.sv
// Shared types, codes and the texel read schedule of the bump map gradient sampler.
// No dependencies; every file but bmg_ram and bmg_fifo uses this package.
package bmg_pkg;

    localparam int MAP_IDX_W   = 11;
    localparam int MAP_ADDR_W  = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_DATA_W  = 16;

    localparam logic       CMD_LOAD  = 1'b0;
    localparam logic       CMD_QUERY = 1'b1;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_FLAT  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_PERSIST = 2'd2;

    // Neighbor offsets: minus one, zero, plus one, plus two (all wrapping)
    localparam logic [1:0] SEL_M1 = 2'd0;
    localparam logic [1:0] SEL_0  = 2'd1;
    localparam logic [1:0] SEL_P1 = 2'd2;
    localparam logic [1:0] SEL_P2 = 2'd3;

    typedef struct packed {
        logic               command;
        logic [15:0]        texel_index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic signed [31:0] u_coord;
        logic signed [31:0] v_coord;
    } item_t;

    typedef struct packed {
        logic signed [23:0] gradient_u;
        logic signed [23:0] gradient_v;
        logic               flat;
    } result_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [MAP_ADDR_W-1:0] addr;
        logic [7:0]            mean;
        logic [MAP_IDX_W-1:0]  col;
        logic [MAP_IDX_W-1:0]  row;
        logic [15:0]           dx;
        logic [15:0]           dy;
    } entry_t;

    typedef struct packed {
        logic [1:0] csel;
        logic [1:0] rsel;
        logic       xsel;
        logic       ysel;
        logic       neg;
        logic       is_v;
    } step_t;

    // Steps 0..7 build the u difference, 8..15 the v difference.
    function automatic step_t step_decode(input logic [3:0] k);
        step_t s;
        s = '0;
        if (!k[3]) begin
            s.is_v = 1'b0;
            s.rsel = k[2] ? SEL_P1 : SEL_0;
            s.ysel = k[2];
            case (k[1:0])
                2'd0:    begin s.csel = SEL_P1; s.xsel = 1'b0; s.neg = 1'b0; end
                2'd1:    begin s.csel = SEL_P2; s.xsel = 1'b1; s.neg = 1'b0; end
                2'd2:    begin s.csel = SEL_M1; s.xsel = 1'b0; s.neg = 1'b1; end
                default: begin s.csel = SEL_0;  s.xsel = 1'b1; s.neg = 1'b1; end
            endcase
        end else begin
            s.is_v = 1'b1;
            s.csel = k[0] ? SEL_P1 : SEL_0;
            s.xsel = k[0];
            case (k[2:1])
                2'd0:    begin s.rsel = SEL_M1; s.ysel = 1'b0; s.neg = 1'b0; end
                2'd1:    begin s.rsel = SEL_0;  s.ysel = 1'b1; s.neg = 1'b0; end
                2'd2:    begin s.rsel = SEL_P1; s.ysel = 1'b0; s.neg = 1'b1; end
                default: begin s.rsel = SEL_P2; s.ysel = 1'b1; s.neg = 1'b1; end
            endcase
        end
        return s;
    endfunction

endpackage

### sv/bmg_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bmg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/bmg_fifo.sv
// Small register queue between the front and back parts of the sampler.
// No dependencies.
module bmg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic [CW-1:0]    count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

endmodule

### sv/bmg_front.sv
// Front part: accepts words, averages load colors, wraps query coordinates
// into texel position and weights, and pushes classified entries. Uses bmg_pkg.
module bmg_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    localparam int WB        = $clog2(MAX_WIDTH + 1),
    localparam int HB        = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  bmg_pkg::item_t              item,
    input  logic [WB-1:0]               w_eff,
    input  logic [HB-1:0]               h_eff,
    input  logic [15:0]                 persistence,
    input  logic [bmg_pkg::CNT_W-1:0]   q_count,
    output logic                        busy,
    output logic                        push,
    output bmg_pkg::entry_t             push_entry
);

    import bmg_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic              v0_reg, v1_reg, v2_reg;
    logic              cmd0_reg, cmd1_reg, cmd2_reg;
    logic [15:0]       idx0_reg, idx1_reg, idx2_reg;
    logic [9:0]        sum0_reg;
    logic [23:0]       u0_reg, vc0_reg;
    logic              inr1_reg, inr2_reg;
    logic [7:0]        mean1_reg, mean2_reg;
    logic [23:0]       fu1_reg, fv1_reg;
    logic [WB+23:0]    px2_reg;
    logic [HB+24:0]    ry2_reg;

    logic              accept;
    logic [CNT_W:0]    load_sum;
    logic [39:0]       mu, mv;
    logic [19:0]       prod3;
    logic [WB-1:0]     colw, col;
    logic [HB-1:0]     roww, row;

    // Credit: never let the queue overflow, counting words still in flight
    assign load_sum = (CNT_W + 1)'(q_count) + (CNT_W + 1)'(v0_reg)
                    + (CNT_W + 1)'(v1_reg) + (CNT_W + 1)'(v2_reg);
    assign busy     = load_sum >= (CNT_W + 1)'(QUEUE_DEPTH);
    assign accept   = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // Low 24 bits of coordinate times persistence are the wrapped fraction
    assign mu    = 40'(u0_reg) * 40'(persistence);
    assign mv    = 40'(vc0_reg) * 40'(persistence);
    // Divide by three: multiply by 683/2048, exact for sums up to 765
    assign prod3 = 20'(sum0_reg) * 20'd683;

    always_ff @(posedge clk)
    begin
        cmd0_reg  <= item.command;
        idx0_reg  <= item.texel_index;
        sum0_reg  <= 10'(item.red) + 10'(item.green) + 10'(item.blue);
        u0_reg    <= item.u_coord[23:0];
        vc0_reg   <= item.v_coord[23:0];

        cmd1_reg  <= cmd0_reg;
        idx1_reg  <= idx0_reg;
        inr1_reg  <= 32'(idx0_reg) < 32'(DEPTH);
        mean1_reg <= prod3[18:11];
        fu1_reg   <= mu[23:0];
        fv1_reg   <= mv[23:0];

        cmd2_reg  <= cmd1_reg;
        idx2_reg  <= idx1_reg;
        inr2_reg  <= inr1_reg;
        mean2_reg <= mean1_reg;
        px2_reg   <= (WB + 24)'(w_eff) * (WB + 24)'(fu1_reg);
        // Flipped rows: position is h * (1 - fraction)
        ry2_reg   <= (HB + 25)'(h_eff) * (HB + 25)'(25'h1000000 - 25'(fv1_reg));
    end

    assign colw = px2_reg[WB+23:24];
    assign roww = ry2_reg[HB+23:24];
    assign col  = (colw >= w_eff) ? '0 : colw;
    assign row  = (roww >= h_eff) ? '0 : roww;

    always_comb
    begin
        push_entry      = '0;
        push_entry.addr = MAP_ADDR_W'(idx2_reg);
        push_entry.mean = mean2_reg;
        push_entry.col  = MAP_IDX_W'(col);
        push_entry.row  = MAP_IDX_W'(row);
        push_entry.dx   = px2_reg[23:8];
        push_entry.dy   = ry2_reg[23:8];
        if (cmd2_reg == CMD_LOAD)
        begin
            push_entry.kind = KIND_LOAD;
        end
        else if (w_eff == WB'(1) && h_eff == HB'(1))
        begin
            push_entry.kind = KIND_FLAT;
        end
        else
        begin
            push_entry.kind = KIND_QUERY;
        end
    end

    // Drop loads that fall outside the map
    assign push = v2_reg && (cmd2_reg == CMD_QUERY || inr2_reg);

endmodule

### sv/bmg_back.sv
// Back part: writes loads into the height map and, for a query, reads sixteen
// texels through one port and accumulates both central differences. Uses bmg_pkg.
module bmg_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    localparam int WB        = $clog2(MAX_WIDTH + 1),
    localparam int HB        = $clog2(MAX_HEIGHT + 1),
    localparam int AW        = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WB-1:0]     w_eff,
    input  logic [HB-1:0]     h_eff,
    input  logic              q_nonempty,
    input  bmg_pkg::entry_t   head,
    output logic              pop,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [7:0]        wr_data,
    output logic [AW-1:0]     rd_addr,
    input  logic [7:0]        rd_data,
    output logic              result_valid,
    output bmg_pkg::result_t  result
);

    import bmg_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_RUN  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam int ACC_W  = 42;
    localparam int MAG_W  = 41;
    localparam int PROD_W = 41;
    localparam logic [4:0] STEPS = 5'd16;

    typedef struct packed {
        logic v;
        logic neg;
        logic is_v;
        logic xsel;
        logic ysel;
    } tag_t;

    logic [2:0]               state_reg, state_next;
    logic [4:0]               k_reg, k_next;
    tag_t                     t0_reg, t0_next, t1_reg, t2_reg;
    logic                     res_v_reg, res_v_next;
    entry_t                   cur_reg;
    result_t                  res_reg;
    logic [WB-1:0]            cm1_reg, c0_reg, cp1_reg, cp2_reg;
    logic [HB-1:0]            rm1_reg, r0_reg, rp1_reg, rp2_reg;
    logic [32:0]              wt_reg [4];
    logic [AW-1:0]            rd_addr_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [ACC_W-1:0]  accu_reg, accv_reg;
    logic                     negu_reg, negv_reg;
    logic [MAG_W+WB-1:0]      mu_reg;
    logic [MAG_W+HB-1:0]      mv_reg;

    logic [WB-1:0]            c0w, cp1w, cp2w, cm1w, csel_col;
    logic [HB-1:0]            r0w, rp1w, rp2w, rm1w, rsel_row;
    logic [16:0]              wx0, wx1, wy0, wy1;
    logic [33:0]              w00, w01, w10, w11;
    step_t                    st;
    logic [AW-1:0]            addr;
    logic signed [ACC_W-1:0]  term;
    logic [MAG_W-1:0]         magu, magv;
    logic [MAG_W+WB-1:0]      su;
    logic [MAG_W+HB-1:0]      sv;
    logic [23:0]              mu_clip, mv_clip;

    // Wrapped neighbor indices
    assign c0w  = WB'(cur_reg.col);
    assign cp1w = (c0w + WB'(1) >= w_eff) ? '0 : c0w + WB'(1);
    assign cp2w = (cp1w + WB'(1) >= w_eff) ? '0 : cp1w + WB'(1);
    assign cm1w = (c0w == '0) ? w_eff - WB'(1) : c0w - WB'(1);
    assign r0w  = HB'(cur_reg.row);
    assign rp1w = (r0w + HB'(1) >= h_eff) ? '0 : r0w + HB'(1);
    assign rp2w = (rp1w + HB'(1) >= h_eff) ? '0 : rp1w + HB'(1);
    assign rm1w = (r0w == '0) ? h_eff - HB'(1) : r0w - HB'(1);

    assign wx0 = 17'h10000 - 17'(cur_reg.dx);
    assign wx1 = 17'(cur_reg.dx);
    assign wy0 = 17'h10000 - 17'(cur_reg.dy);
    assign wy1 = 17'(cur_reg.dy);
    assign w00 = 34'(wx0) * 34'(wy0);
    assign w01 = 34'(wx0) * 34'(wy1);
    assign w10 = 34'(wx1) * 34'(wy0);
    assign w11 = 34'(wx1) * 34'(wy1);

    assign st = step_decode(k_reg[3:0]);

    always_comb
    begin
        case (st.csel)
            SEL_M1:  csel_col = cm1_reg;
            SEL_0:   csel_col = c0_reg;
            SEL_P1:  csel_col = cp1_reg;
            default: csel_col = cp2_reg;
        endcase
        case (st.rsel)
            SEL_M1:  rsel_row = rm1_reg;
            SEL_0:   rsel_row = r0_reg;
            SEL_P1:  rsel_row = rp1_reg;
            default: rsel_row = rp2_reg;
        endcase
    end

    assign addr = AW'(rsel_row) * AW'(w_eff) + AW'(csel_col);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        t0_next    = '0;
        res_v_next = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_nonempty)
                begin
                    pop = 1'b1;
                    if (head.kind == KIND_FLAT)
                    begin
                        res_v_next = 1'b1;
                    end
                    else if (head.kind == KIND_QUERY)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                k_next     = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (k_reg < STEPS)
                begin
                    t0_next.v    = 1'b1;
                    t0_next.neg  = st.neg;
                    t0_next.is_v = st.is_v;
                    t0_next.xsel = st.xsel;
                    t0_next.ysel = st.ysel;
                    k_next       = k_reg + 5'd1;
                end
                else if (!t0_reg.v && !t1_reg.v && !t2_reg.v)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                res_v_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            t0_reg    <= '0;
            t1_reg    <= '0;
            t2_reg    <= '0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            t0_reg    <= t0_next;
            t1_reg    <= t0_reg;
            t2_reg    <= t1_reg;
            res_v_reg <= res_v_next;
        end
    end

    assign term = t2_reg.neg ? -$signed(ACC_W'(prod_reg)) : $signed(ACC_W'(prod_reg));
    assign magu = MAG_W'(accu_reg[ACC_W-1] ? -accu_reg : accu_reg);
    assign magv = MAG_W'(accv_reg[ACC_W-1] ? -accv_reg : accv_reg);

    // Shift from Q.32 times full scale to Q.8 times half scale
    assign su      = mu_reg >> 25;
    assign sv      = mv_reg >> 25;
    assign mu_clip = (su > (MAG_W + WB)'(24'h7FFFFF)) ? 24'h7FFFFF : 24'(su);
    assign mv_clip = (sv > (MAG_W + HB)'(24'h7FFFFF)) ? 24'h7FFFFF : 24'(sv);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (state_reg == ST_PREP)
        begin
            cm1_reg   <= cm1w;
            c0_reg    <= c0w;
            cp1_reg   <= cp1w;
            cp2_reg   <= cp2w;
            rm1_reg   <= rm1w;
            r0_reg    <= r0w;
            rp1_reg   <= rp1w;
            rp2_reg   <= rp2w;
            wt_reg[0] <= w00[32:0];
            wt_reg[1] <= w01[32:0];
            wt_reg[2] <= w10[32:0];
            wt_reg[3] <= w11[32:0];
            accu_reg  <= '0;
            accv_reg  <= '0;
        end
        else if (t2_reg.v)
        begin
            if (t2_reg.is_v)
            begin
                accv_reg <= accv_reg + term;
            end
            else
            begin
                accu_reg <= accu_reg + term;
            end
        end
        rd_addr_reg <= addr;
        prod_reg    <= PROD_W'(rd_data) * PROD_W'(wt_reg[{t1_reg.xsel, t1_reg.ysel}]);
        if (state_reg == ST_MUL)
        begin
            negu_reg <= accu_reg[ACC_W-1];
            negv_reg <= accv_reg[ACC_W-1];
            mu_reg   <= (MAG_W + WB)'(magu) * (MAG_W + WB)'(w_eff);
            mv_reg   <= (MAG_W + HB)'(magv) * (MAG_W + HB)'(h_eff);
        end
        if (state_reg == ST_OUT)
        begin
            res_reg.gradient_u <= negu_reg ? -$signed(mu_clip) : $signed(mu_clip);
            res_reg.gradient_v <= negv_reg ? -$signed(mv_clip) : $signed(mv_clip);
            res_reg.flat       <= 1'b0;
        end
        else if (pop && head.kind == KIND_FLAT)
        begin
            res_reg.gradient_u <= '0;
            res_reg.gradient_v <= '0;
            res_reg.flat       <= 1'b1;
        end
    end

    assign wr_en        = pop && head.kind == KIND_LOAD;
    assign wr_addr      = AW'(head.addr);
    assign wr_data      = head.mean;
    assign rd_addr      = rd_addr_reg;
    assign result_valid = res_v_reg;
    assign result       = res_reg;

endmodule

### sv/bump_map_gradient_sampler.sv
// Top level of the bump map gradient sampler: configuration registers, front,
// queue, back and height map RAM. Uses bmg_pkg, bmg_front, bmg_fifo, bmg_back, bmg_ram.
//
// Usage:
//   Input words: raise start with a word on item; the word is taken at a clock
//   edge where start is high and busy is low. A load word (command 0) stores
//   the mean of red, green and blue at texel_index and gives no result. A query
//   word (command 1) gives exactly one result word.
//   Results: result_valid is high for one cycle with the word on result; the
//   receiver takes every result and cannot stall the block.
//   Configuration: cfg_valid with cfg_index and cfg_data writes width_used (0),
//   height_used (1) or persistence (2); cfg_ready is always high. Write only
//   while no query is pending.
//   Flow: a query passes the front, the queue and the back states PREP, RUN,
//   MUL and OUT; loads and flat-map queries leave the back part from its idle
//   state. The query rate is set by the sixteen texel reads through the single
//   read port of the height map RAM; the front keeps taking words meanwhile while
//   the queue credit allows. Loads are held back by the queue credit in the front part.
//   Reset: width and height return to 1, persistence to 1.0; the queue empties.
//   The height map keeps its contents and must be loaded before it is read.
module bump_map_gradient_sampler #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bmg_pkg::item_t                 item,
    output logic                           result_valid,
    output bmg_pkg::result_t               result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [bmg_pkg::CFG_DATA_W-1:0] cfg_data
);

    import bmg_pkg::*;

    localparam int WB      = $clog2(MAX_WIDTH + 1);
    localparam int HB      = $clog2(MAX_HEIGHT + 1);
    localparam int AW      = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int ENTRY_W = $bits(entry_t);

    logic [8:0]         width_reg, height_reg;
    logic [15:0]        persist_reg;
    logic [WB-1:0]      w_eff;
    logic [HB-1:0]      h_eff;
    logic               push, pop;
    entry_t             push_entry, head;
    logic [ENTRY_W-1:0] head_bits;
    logic [CNT_W-1:0]   q_count;
    logic               wr_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [7:0]         wr_data, rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= 9'd1;
            height_reg  <= 9'd1;
            persist_reg <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:   width_reg   <= cfg_data[8:0];
                REG_HEIGHT:  height_reg  <= cfg_data[8:0];
                REG_PERSIST: persist_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Clamp dimensions: zero acts as one, anything past the maximum as the maximum
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WB'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WB'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WB'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = HB'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = HB'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HB'(height_reg);
        end
    end

    bmg_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .w_eff       (w_eff),
        .h_eff       (h_eff),
        .persistence (persist_reg),
        .q_count     (q_count),
        .busy        (busy),
        .push        (push),
        .push_entry  (push_entry)
    );

    bmg_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .pop_data  (head_bits),
        .count     (q_count)
    );

    assign head = entry_t'(head_bits);

    bmg_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .w_eff        (w_eff),
        .h_eff        (h_eff),
        .q_nonempty   (q_count != '0),
        .head         (head),
        .pop          (pop),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .result       (result)
    );

    bmg_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

### sv/bmg_checker.sv
// Port-level checks for the bump map gradient sampler, bound to the top level.
// Uses bmg_pkg.
module bmg_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input bmg_pkg::item_t                 item,
    input logic                           result_valid,
    input bmg_pkg::result_t               result,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [1:0]                     cfg_index,
    input logic [bmg_pkg::CFG_DATA_W-1:0] cfg_data
);

    // A flat result carries no slope
    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.flat |-> result.gradient_u == '0 && result.gradient_v == '0)
        else $error("flat result with nonzero gradient");

    // Saturation is symmetric, so the most negative code never appears
    a_sym_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.gradient_u != 24'h800000 && result.gradient_v != 24'h800000)
        else $error("gradient outside symmetric range");

    // No result word right out of reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !result_valid)
        else $error("result right after reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind bump_map_gradient_sampler bmg_checker u_chk (.*);

### bench/bump_map_gradient_checker.sv
// Checker for the bump map gradient sampler: predicts each query's gradients and
// compares them with the result words. Depends on bmg_pkg.
module bump_map_gradient_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  bmg_pkg::item_t                 item,
    input  logic                           result_valid,
    input  bmg_pkg::result_t               result,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [bmg_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatch_count,
    output int                             pending_results
);
    import bmg_pkg::*;

    localparam int MAP_W = 256;
    localparam int MAP_H = 256;
    localparam longint GRAD_MAX = 64'd8388607;

    logic [7:0]  texels [0:MAP_W*MAP_H-1];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [15:0] persist_reg;
    result_t     expected_grads [$];

    function automatic int unsigned eff_dim(input logic [8:0] d, input int unsigned lim);
        if (d == 0)
            return 1;
        if (d > lim)
            return lim;
        return d;
    endfunction

    function automatic int unsigned step_up(input int unsigned i, input int unsigned n);
        return (i + 1 >= n) ? 0 : i + 1;
    endfunction

    function automatic int unsigned step_down(input int unsigned i, input int unsigned n);
        return (i == 0) ? n - 1 : i - 1;
    endfunction

    function automatic logic [23:0] wrapped_frac(input logic [31:0] c);
        logic [63:0] wide;
        logic [63:0] prod;
        wide = {{32{c[31]}}, c};
        prod = wide * {48'd0, persist_reg};
        return prod[23:0];
    endfunction

    function automatic logic [63:0] texel_at(input int unsigned col, input int unsigned row,
                                             input int unsigned w);
        return {56'd0, texels[row * w + col]};
    endfunction

    // Bilinear blend of a 2x2 patch, Q8.32
    function automatic logic [63:0] blend(input int unsigned col, input int unsigned row,
                                          input int unsigned w, input int unsigned h,
                                          input logic [63:0] dx, input logic [63:0] dy);
        int unsigned c1;
        int unsigned r1;
        logic [63:0] top;
        logic [63:0] bot;
        c1  = step_up(col, w);
        r1  = step_up(row, h);
        top = texel_at(col, row, w) * (64'd65536 - dx) + texel_at(c1, row, w) * dx;
        bot = texel_at(col, r1, w) * (64'd65536 - dx) + texel_at(c1, r1, w) * dx;
        return top * (64'd65536 - dy) + bot * dy;
    endfunction

    // Difference scaled by half the dimension, truncated toward zero, saturated
    function automatic logic [23:0] scaled_slope(input logic [63:0] a, input logic [63:0] b,
                                                 input int unsigned scale);
        longint d;
        logic [63:0] mag;
        longint v;
        d   = longint'(a) - longint'(b);
        mag = (d < 0) ? -d : d;
        mag = (mag * scale) >> 25;
        if (mag > GRAD_MAX)
            mag = GRAD_MAX;
        v = (d < 0) ? -longint'(mag) : longint'(mag);
        return v[23:0];
    endfunction

    function automatic result_t predict_gradient(input item_t q);
        result_t r;
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        logic [63:0] px;
        logic [63:0] ry;
        logic [63:0] dx;
        logic [63:0] dy;
        r = '0;
        w = eff_dim(width_reg, MAP_W);
        h = eff_dim(height_reg, MAP_H);
        if (w == 1 && h == 1) begin
            r.flat = 1'b1;
            return r;
        end
        px  = 64'(w) * {40'd0, wrapped_frac(q.u_coord)};
        col = px >> 24;
        if (col >= w)
            col = 0;
        dx  = {48'd0, px[23:8]};
        ry  = (64'(h) << 24) - 64'(h) * {40'd0, wrapped_frac(q.v_coord)};
        row = ry >> 24;
        if (row >= h)
            row = 0;
        dy  = {48'd0, ry[23:8]};
        r.gradient_u = scaled_slope(blend(step_up(col, w), row, w, h, dx, dy),
                                    blend(step_down(col, w), row, w, h, dx, dy), w);
        r.gradient_v = scaled_slope(blend(col, step_down(row, h), w, h, dx, dy),
                                    blend(col, step_up(row, h), w, h, dx, dy), h);
        return r;
    endfunction

    assign pending_results = expected_grads.size();

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            width_reg      <= 9'd1;
            height_reg     <= 9'd1;
            persist_reg    <= 16'd256;
            mismatch_count <= 0;
            expected_grads.delete();
        end else begin
            if (result_valid) begin
                if (expected_grads.size() == 0) begin
                    $display("%0t unexpected result word %h", $time, result);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_grads.pop_front();
                    if (want.gradient_u !== result.gradient_u
                        || want.gradient_v !== result.gradient_v
                        || want.flat !== result.flat) begin
                        $display("%0t mismatch: expected u=%h v=%h flat=%b, got u=%h v=%h flat=%b",
                                 $time, want.gradient_u, want.gradient_v, want.flat,
                                 result.gradient_u, result.gradient_v, result.flat);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                if (item.command == CMD_QUERY)
                    expected_grads.push_back(predict_gradient(item));
                else
                    texels[item.texel_index] <=
                        8'((10'(item.red) + 10'(item.green) + 10'(item.blue)) / 10'd3);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WIDTH:   width_reg   <= cfg_data[8:0];
                    REG_HEIGHT:  height_reg  <= cfg_data[8:0];
                    REG_PERSIST: persist_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

### bench/bump_map_gradient_sampler_tb.sv
// Top of the bump map gradient sampler bench: clock, reset, stimulus and verdict.
// Depends on bmg_pkg, bump_map_gradient_sampler and bump_map_gradient_checker.
module bump_map_gradient_sampler_tb;
    import bmg_pkg::*;

    localparam int SETTLE_CYCLES = 40;     // beyond the query latency
    localparam int STALL_LIMIT   = 5000;   // cycles with no word moving
    localparam int FILL_TEXELS   = 384;    // every map of the run fits in these
    localparam int GROUPS        = 8;
    localparam int PER_GROUP     = 30;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  result_valid;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatch_count;
    int                    pending_results;
    int                    idle_pct;
    int                    stall_cycles;

    bump_map_gradient_sampler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bump_map_gradient_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .item            (item),
        .result_valid    (result_valid),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always #6 clk = ~clk;

    // Watchdog: count cycles in which no word moves on any channel
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL bump_map_gradient_sampler");
            $finish;
        end
    end

    // Send one input word; idle at random first, keep start high if the next
    // word follows straight away
    task automatic send_word(input item_t w);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic send_load(input logic [15:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
        item_t w;
        w             = '0;
        w.command     = CMD_LOAD;
        w.texel_index = idx;
        w.red         = r;
        w.green       = g;
        w.blue        = b;
        w.u_coord     = $urandom;
        w.v_coord     = $urandom;
        send_word(w);
    endtask

    task automatic send_query(input logic [31:0] u, input logic [31:0] v);
        item_t w;
        w             = '0;
        w.command     = CMD_QUERY;
        w.texel_index = $urandom;
        w.red         = $urandom;
        w.green       = $urandom;
        w.blue        = $urandom;
        w.u_coord     = u;
        w.v_coord     = v;
        send_word(w);
    endtask

    // Drop start and hold until every expected result is back and the pipe drains
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_map(input logic [8:0] w, input logic [8:0] h,
                           input logic [15:0] p);
        drain();
        write_reg(REG_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_PERSIST, p);
    endtask

    // Mostly small maps so that edges and wrap come up often
    function automatic logic [8:0] pick_dim;
        int k;
        k = $urandom_range(99);
        if (k < 60)
            return $urandom_range(1, 8);
        if (k < 85)
            return $urandom_range(9, 256);
        if (k < 92)
            return (k < 88) ? 9'd0 : 9'd256;
        return $urandom_range(257, 511);
    endfunction

    // Height for a given width that keeps the map inside the filled texels
    function automatic logic [8:0] pick_height(input logic [8:0] w);
        int we;
        int lim;
        int k;
        we  = (w == 9'd0) ? 1 : (w > 9'd256) ? 256 : int'(w);
        lim = FILL_TEXELS / we;
        k   = $urandom_range(99);
        if (k < 10)
            return 9'd0;
        if (lim >= 256 && k < 20)
            return 9'($urandom_range(257, 511));
        if (lim > 256)
            lim = 256;
        return 9'($urandom_range(1, lim));
    endfunction

    function automatic logic [15:0] pick_persist;
        int k;
        k = $urandom_range(99);
        if (k < 35)
            return 16'd256;
        if (k < 45)
            return 16'd0;
        if (k < 50)
            return 16'hFFFF;
        return $urandom;
    endfunction

    initial begin
        logic [31:0] u;
        logic [31:0] v;
        logic [8:0]  pw;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_WIDTH;
        cfg_data     = '0;
        stall_cycles = 0;
        idle_pct     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every texel that a map of this run can reach
        for (int a = 0; a < FILL_TEXELS; a++)
            send_load(16'(a), $urandom, $urandom, $urandom);

        // Directed: a flat map at reset values, then with zero dimensions
        idle_pct = 30;
        send_query(32'h7FFF_FFFF, 32'h8000_0000);
        set_map(9'd0, 9'd0, 16'd256);
        send_query(32'h0, 32'hFFFF_FFFF);

        // Directed: extreme colors at both ends of the store
        send_load(16'h0000, 8'hFF, 8'hFF, 8'hFF);
        send_load(16'hFFFF, 8'h00, 8'h00, 8'h00);
        send_load(16'h0001, 8'hFF, 8'h00, 8'hFF);

        // Directed: widest and tallest maps, coordinate extremes
        set_map(9'd256, 9'd1, 16'd256);
        send_query(32'h0, 32'h0);
        send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_query(32'h8000_0000, 32'h8000_0000);
        set_map(9'd1, 9'd256, 16'd256);
        send_query(32'hFFFF_FFFF, 32'h0000_8000);
        send_query(32'h0000_FFFF, 32'hFFFF_0000);

        // Directed: zero and largest persistence, oversized and thin maps
        set_map(9'd511, 9'd0, 16'd0);
        send_query(32'h1234_5678, 32'h8765_4321);
        set_map(9'd0, 9'd300, 16'hFFFF);
        send_query(32'h1234_5678, 32'h8765_4321);
        set_map(9'd2, 9'd1, 16'hFFFF);
        send_query(32'h7FFF_FFFF, 32'h8000_0001);
        set_map(9'd1, 9'd2, 16'h0001);
        send_query(32'hFFFF_FFFF, 32'h0000_0001);
        set_map(9'd3, 9'd5, 16'd384);
        send_query(32'h0002_8000, 32'hFFFD_4000);

        // Random: three idle profiles, each in groups between config changes
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 30 : (phase == 1) ? 65 : 0;
            for (int grp = 0; grp < GROUPS; grp++) begin
                pw = pick_dim();
                set_map(pw, pick_height(pw), pick_persist());
                for (int n = 0; n < PER_GROUP; n++) begin
                    if ($urandom_range(99) < 25) begin
                        send_load($urandom, $urandom, $urandom, $urandom);
                    end else begin
                        u = $urandom;
                        v = $urandom;
                        // Keep some coordinates near zero to stay close to the map origin
                        if ($urandom_range(3) == 0) begin
                            u = {{14{u[31]}}, u[17:0]};
                            v = {{14{v[31]}}, v[17:0]};
                        end
                        send_query(u, v);
                    end
                end
            end
        end

        drain();
        if (mismatch_count == 0 && pending_results == 0)
            $display("PASS bump_map_gradient_sampler");
        else
            $display("FAIL bump_map_gradient_sampler");
        $finish;
    end

endmodule
